FILE: design/tafsm_pkg.sv
// ---------------------------------------------------------------------------
// tafsm_pkg: shared types and constants of the tracker availability FSM
// Payload structs, pipeline stage records, mode codes and register indexes.
// ---------------------------------------------------------------------------
package tafsm_pkg;

  localparam int unsigned VecW   = 20;               // vector component width
  localparam int unsigned MagW   = VecW;             // magnitude of a component
  localparam int unsigned SqW    = 2 * MagW;         // one squared component / norm
  localparam int unsigned StepW  = 20;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LimW   = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ModeW  = 2;

  // Output mode codes
  localparam logic [ModeW-1:0] MODE_LOST  = 2'd0;
  localparam logic [ModeW-1:0] MODE_ACQ   = 2'd1;
  localparam logic [ModeW-1:0] MODE_TRACK = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TRACK_RATE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRACK_ACCEL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACQUIRE_RATE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACQUIRE_ACCEL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REACQ_TIME    = 3'd4;

  typedef enum logic [2:0] {
    ST_LOST  = 3'b001,
    ST_ACQ   = 3'b010,
    ST_TRACK = 3'b100
  } mode_t;

  typedef struct packed {
    logic [StepW-1:0]       step_us;
    logic signed [VecW-1:0] rate_x;
    logic signed [VecW-1:0] rate_y;
    logic signed [VecW-1:0] rate_z;
    logic signed [VecW-1:0] accel_x;
    logic signed [VecW-1:0] accel_y;
    logic signed [VecW-1:0] accel_z;
    logic                   occluded;
    logic                   dropout;
  } in_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             valid_res;
    logic [TimeW-1:0] elapsed_us;
    logic             rate_trip;
    logic             accel_trip;
  } out_t;

  // Squared components, one per axis of rate and of acceleration
  typedef struct packed {
    logic [StepW-1:0] step_us;
    logic             geo_ok;
    logic [SqW-1:0]   rsq_x;
    logic [SqW-1:0]   rsq_y;
    logic [SqW-1:0]   rsq_z;
    logic [SqW-1:0]   asq_x;
    logic [SqW-1:0]   asq_y;
    logic [SqW-1:0]   asq_z;
  } sq_t;

  // Envelope check outcome
  typedef struct packed {
    logic [StepW-1:0] step_us;
    logic             geo_ok;
    logic             tr_ok;
    logic             ta_ok;
    logic             ar_ok;
    logic             aa_ok;
  } chk_t;

  // Squared limits as held after a configuration write
  typedef struct packed {
    logic           en;     // limit is nonzero, check active
    logic [SqW-1:0] sq;
  } lim_t;

  typedef struct packed {
    lim_t track_rate;
    lim_t track_accel;
    lim_t acq_rate;
    lim_t acq_accel;
  } lims_t;

  function automatic logic [MagW-1:0] mag(input logic signed [VecW-1:0] v);
    logic [MagW-1:0] u;
    u = v;
    mag = v[VecW-1] ? (~u + {{(MagW-1){1'b0}}, 1'b1}) : u;
  endfunction

  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    case (m)
      ST_TRACK: c = MODE_TRACK;
      ST_ACQ:   c = MODE_ACQ;
      default:  c = MODE_LOST;
    endcase
    mode_code = c;
  endfunction

endpackage

FILE: design/tracker_availability_fsm.sv
// ---------------------------------------------------------------------------
// tracker_availability_fsm: availability state machine of an attitude tracker
// Four-stage pipeline: input register, squaring, envelope check, mode FSM.
// ---------------------------------------------------------------------------
// One transfer in gives one transfer out, and a new step is taken every cycle
// while the result side is not stalled. A step passes the four register stages
// in order: input register, component squares (one 20x20 multiplier per
// component), norm sum and limit compare, and the mode/timer update
// feeding the result register. Each stage holds its own item and only stalls
// when the stage after it is full and stalled, so bubbles are squeezed out.
// Limits are squared once at configuration time; a zero limit switches its
// check off. Write the configuration only while the pipeline is empty.
module tracker_availability_fsm import tafsm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // step input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration: limits are held already squared, with an enable for nonzero
  lims_t            lims_r;
  logic [TimeW-1:0] reacq_r;
  lim_t             cfg_lim;
  logic [LimW-1:0]  cfg_l;

  assign cfg_l      = cfg_wdata[LimW-1:0];
  assign cfg_lim.en = (cfg_l != '0);
  assign cfg_lim.sq = cfg_l * cfg_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lims_r  <= '0;
      reacq_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TRACK_RATE:    lims_r.track_rate  <= cfg_lim;
        CFG_TRACK_ACCEL:   lims_r.track_accel <= cfg_lim;
        CFG_ACQUIRE_RATE:  lims_r.acq_rate    <= cfg_lim;
        CFG_ACQUIRE_ACCEL: lims_r.acq_accel   <= cfg_lim;
        CFG_REACQ_TIME:    reacq_r            <= cfg_wdata[TimeW-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Input register: hold the step until the squaring stage has room
  logic in_v_r;
  in_t  in_d_r;
  logic sq_in_ready;

  assign in_ready = !in_v_r || sq_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_d_r <= in_data;
    end
  end

  // Squaring stage
  logic sq_v, chk_in_ready;
  sq_t  sq_d;

  tafsm_sq u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_v_r),
    .i_ready (sq_in_ready),
    .i_data  (in_d_r),
    .o_valid (sq_v),
    .o_ready (chk_in_ready),
    .o_data  (sq_d)
  );

  // Envelope check stage
  logic chk_v, core_in_ready;
  chk_t chk_d;

  tafsm_chk u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .lims    (lims_r),
    .i_valid (sq_v),
    .i_ready (chk_in_ready),
    .i_data  (sq_d),
    .o_valid (chk_v),
    .o_ready (core_in_ready),
    .o_data  (chk_d)
  );

  // Mode FSM and result register; state advances only on a real transfer
  tafsm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .reacq_time (reacq_r),
    .i_valid    (chk_v),
    .i_ready    (core_in_ready),
    .i_data     (chk_d),
    .o_valid    (out_valid),
    .o_ready    (out_ready),
    .o_data     (out_data)
  );

endmodule

FILE: design/tafsm_sq.sv
// ---------------------------------------------------------------------------
// tafsm_sq: component squaring stage
// Takes signed components, forms their magnitudes and registers their squares.
// ---------------------------------------------------------------------------
module tafsm_sq import tafsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic i_valid,
  output logic i_ready,
  input  in_t  i_data,
  output logic o_valid,
  input  logic o_ready,
  output sq_t  o_data
);

  logic v_r;
  sq_t  d_r;
  sq_t  d_nxt;

  logic [MagW-1:0] m_rx, m_ry, m_rz, m_ax, m_ay, m_az;

  assign m_rx = mag(i_data.rate_x);
  assign m_ry = mag(i_data.rate_y);
  assign m_rz = mag(i_data.rate_z);
  assign m_ax = mag(i_data.accel_x);
  assign m_ay = mag(i_data.accel_y);
  assign m_az = mag(i_data.accel_z);

  always_comb begin
    d_nxt.step_us = i_data.step_us;
    d_nxt.geo_ok  = !i_data.occluded && !i_data.dropout;
    d_nxt.rsq_x   = m_rx * m_rx;
    d_nxt.rsq_y   = m_ry * m_ry;
    d_nxt.rsq_z   = m_rz * m_rz;
    d_nxt.asq_x   = m_ax * m_ax;
    d_nxt.asq_y   = m_ay * m_ay;
    d_nxt.asq_z   = m_az * m_az;
  end

  assign i_ready = !v_r || o_ready;
  assign o_valid = v_r;
  assign o_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (i_ready) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: design/tafsm_chk.sv
// ---------------------------------------------------------------------------
// tafsm_chk: envelope check stage
// Sums squared components and compares the norms with the squared limits.
// ---------------------------------------------------------------------------
module tafsm_chk import tafsm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  lims_t lims,
  input  logic  i_valid,
  output logic  i_ready,
  input  sq_t   i_data,
  output logic  o_valid,
  input  logic  o_ready,
  output chk_t  o_data
);

  logic           v_r;
  chk_t           d_r;
  chk_t           d_nxt;
  logic [SqW-1:0] rsq, asq;   // three squares of at most 2^38 fit in SqW

  function automatic logic ok(input logic [SqW-1:0] n, input lim_t l);
    ok = !l.en || (n <= l.sq);
  endfunction

  assign rsq = i_data.rsq_x + i_data.rsq_y + i_data.rsq_z;
  assign asq = i_data.asq_x + i_data.asq_y + i_data.asq_z;

  always_comb begin
    d_nxt.step_us = i_data.step_us;
    d_nxt.geo_ok  = i_data.geo_ok;
    d_nxt.tr_ok   = ok(rsq, lims.track_rate);
    d_nxt.ta_ok   = ok(asq, lims.track_accel);
    d_nxt.ar_ok   = ok(rsq, lims.acq_rate);
    d_nxt.aa_ok   = ok(asq, lims.acq_accel);
  end

  assign i_ready = !v_r || o_ready;
  assign o_valid = v_r;
  assign o_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (i_ready) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: design/tafsm_core.sv
// ---------------------------------------------------------------------------
// tafsm_core: mode state machine and result register
// Updates mode and acquisition timer, registers the result.
// ---------------------------------------------------------------------------
module tafsm_core import tafsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TimeW-1:0] reacq_time,
  input  logic             i_valid,
  output logic             i_ready,
  input  chk_t             i_data,
  output logic             o_valid,
  input  logic             o_ready,
  output out_t             o_data
);

  mode_t            mode_r, mode_nxt;
  logic [TimeW-1:0] timer_r, timer_nxt;
  logic             v_r;
  out_t             d_r, d_nxt;
  logic             step_nz;
  logic             rflag, aflag;
  logic [TimeW:0]   tsum;
  logic [TimeW-1:0] tsat;

  assign step_nz = (i_data.step_us != '0);
  assign tsum    = {1'b0, timer_r} + {{(TimeW + 1 - StepW){1'b0}}, i_data.step_us};
  assign tsat    = tsum[TimeW] ? {TimeW{1'b1}} : tsum[TimeW-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_r;
    rflag     = 1'b0;
    aflag     = 1'b0;
    if (step_nz) begin
      if (!i_data.geo_ok) begin
        mode_nxt  = ST_LOST;
        timer_nxt = '0;
      end else begin
        case (mode_r)
          ST_TRACK: begin
            if (!(i_data.tr_ok && i_data.ta_ok)) begin
              mode_nxt  = ST_LOST;
              timer_nxt = '0;
              rflag     = !i_data.tr_ok;
              aflag     = !i_data.ta_ok;
            end
          end
          default: begin
            if (i_data.ar_ok && i_data.aa_ok) begin
              if (tsat >= reacq_time) begin
                mode_nxt  = ST_TRACK;
                timer_nxt = '0;
              end else begin
                mode_nxt  = ST_ACQ;
                timer_nxt = tsat;
              end
            end else begin
              mode_nxt  = ST_LOST;
              timer_nxt = '0;
              rflag     = !i_data.ar_ok;
              aflag     = !i_data.aa_ok;
            end
          end
        endcase
      end
    end
    d_nxt.mode       = mode_code(mode_nxt);
    d_nxt.valid_res  = step_nz && (mode_nxt == ST_TRACK);
    d_nxt.elapsed_us = timer_nxt;
    d_nxt.rate_trip  = rflag;
    d_nxt.accel_trip = aflag;
  end

  assign i_ready = !v_r || o_ready;
  assign o_valid = v_r;
  assign o_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      mode_r  <= ST_LOST;
      timer_r <= '0;
    end else begin
      if (i_ready) begin
        v_r <= i_valid;
      end
      if (i_ready && i_valid) begin
        mode_r  <= mode_nxt;
        timer_r <= timer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule
